// ----- rtl/bsbe_pkg.sv -----
// Shared types and constants for the B-spline basis evaluator.
package bsbe_pkg;

    localparam int unsigned FRAC_W = 16;
    localparam int unsigned COEF_W = 17;
    localparam int unsigned DIFF_W = 33;
    localparam int unsigned ACC_W  = 35;
    localparam logic [COEF_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic {
        OPER_KNOT_WRITE = 1'b0,
        OPER_EVALUATE   = 1'b1
    } oper_t;

    typedef enum logic {
        CFG_SPLINE_DEGREE = 1'b0,
        CFG_KNOT_COUNT    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic               operation;
        logic [3:0]         knot_index;
        logic signed [31:0] knot_value;
        logic signed [31:0] eval_point;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  basis_index;
        logic [16:0] basis_value;
        logic        last_value;
    } out_word_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_KNOT_WR,
        DP_LOAD_T,
        DP_LD_KA,
        DP_LD_KB,
        DP_LD_KC,
        DP_LD_KD,
        DP_IND,
        DP_DIV_L,
        DP_DIV_R,
        DP_MUL_L,
        DP_MUL_R,
        DP_WB,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

endpackage

// ----- rtl/bspline_basis_evaluator.sv -----
// B-spline basis evaluator: Cox-de Boor recursion over a stored knot table.
// Knot write: stored in the table, no result. Evaluate: a degree-zero indicator pass over
// the knot intervals, then the recursion steps (two sequential divides on one shared divider
// dominate), then the emitted words, each held until the output side accepts it.
// One item in flight at a time. Synchronous active-low reset: degree 3, knot count 8;
// knot table and scratch hold no reset value.
module bspline_basis_evaluator #(
    parameter int unsigned MAX_KNOTS  = 16,
    parameter int unsigned MAX_DEGREE = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [4:0]            cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bsbe_pkg::in_word_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bsbe_pkg::out_word_t   m_data
);
    import bsbe_pkg::*;

    localparam int unsigned KIW = $clog2(MAX_KNOTS);

    dp_cmd_t        cmd;
    dp_status_t     status;
    logic [KIW-1:0] knot_addr, work_addr;
    logic [16:0]    out_value;
    logic [3:0]     m_index;
    logic           m_last;

    bsbe_ctrl #(
        .MAX_KNOTS  (MAX_KNOTS),
        .MAX_DEGREE (MAX_DEGREE),
        .KIW        (KIW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_operation (s_data.operation),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_index     (m_index),
        .m_last      (m_last),
        .cmd         (cmd),
        .knot_addr   (knot_addr),
        .work_addr   (work_addr),
        .status      (status)
    );

    bsbe_datapath #(
        .MAX_KNOTS (MAX_KNOTS),
        .KIW       (KIW)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .knot_addr (knot_addr),
        .work_addr (work_addr),
        .in_word   (s_data),
        .status    (status),
        .out_value (out_value)
    );

    assign m_data.basis_index = m_index;
    assign m_data.basis_value = out_value;
    assign m_data.last_value  = m_last;

endmodule

// ----- rtl/bsbe_div.sv -----
// Sequential saturating Q1.16 divider for the recursion coefficients.
module bsbe_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [bsbe_pkg::DIFF_W-1:0]   num,
    input  logic signed [bsbe_pkg::DIFF_W-1:0]   den,
    output logic                                 done,
    output logic [bsbe_pkg::COEF_W-1:0]          quo
);
    import bsbe_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic [DIFF_W-1:0]     rem_reg, rem_next;
    logic [DIFF_W-1:0]     den_reg, den_next;
    logic [COEF_W-1:0]     quo_reg, quo_next;

    logic [DIFF_W:0]       num_ext, den_ext;
    logic [DIFF_W-1:0]     num_mag, den_mag;
    logic [DIFF_W:0]       shifted;
    logic                  fits;

    always_comb begin
        num_ext = {num[DIFF_W-1], num};
        den_ext = {den[DIFF_W-1], den};
        num_mag = num[DIFF_W-1] ? DIFF_W'(-num_ext) : num;
        den_mag = den[DIFF_W-1] ? DIFF_W'(-den_ext) : den;
        shifted = {rem_reg, 1'b0};
        fits    = shifted >= {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start) begin
            den_next = den_mag;
            rem_next = num_mag;
            cnt_next = 5'(FRAC_W);
            quo_next = '0;
            if (den == '0 || num == '0 || (num[DIFF_W-1] != den[DIFF_W-1])) begin
                done_next = 1'b1;
                busy_next = 1'b0;
            end else if (num_mag >= den_mag) begin
                quo_next  = ONE_Q16;
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = fits ? DIFF_W'(shifted - {1'b0, den_reg}) : shifted[DIFF_W-1:0];
            quo_next = {quo_reg[COEF_W-2:0], fits};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- rtl/bsbe_datapath.sv -----
// Datapath: knot table, basis scratch, divider and multiply-accumulate.
module bsbe_datapath #(
    parameter int unsigned MAX_KNOTS = 16,
    parameter int unsigned KIW = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bsbe_pkg::dp_cmd_t     cmd,
    input  logic [KIW-1:0]        knot_addr,
    input  logic [KIW-1:0]        work_addr,
    input  bsbe_pkg::in_word_t    in_word,
    output bsbe_pkg::dp_status_t  status,
    output logic [16:0]           out_value
);
    import bsbe_pkg::*;

    logic signed [31:0]  knot_mem [MAX_KNOTS];
    logic [COEF_W-1:0]   work_mem [MAX_KNOTS-1];

    logic signed [31:0]  t_reg, ka_reg, kb_reg, kc_reg, kd_reg;
    logic [COEF_W-1:0]   l_reg, r_reg, out_reg;
    logic                sel_r_reg;
    logic [ACC_W-1:0]    acc_reg;

    logic signed [31:0]     knot_q;
    logic [COEF_W-1:0]      work_q;
    logic signed [DIFF_W-1:0] div_num, div_den;
    logic                   div_done;
    logic [COEF_W-1:0]      div_quo;
    logic [COEF_W-1:0]      mul_coef;
    logic [2*COEF_W-1:0]    prod;
    logic [ACC_W-FRAC_W-1:0] acc_sh;
    logic [COEF_W-1:0]      wb_val;
    logic                   ind;

    assign knot_q = knot_mem[knot_addr];
    assign work_q = work_mem[work_addr];

    always_comb begin
        if (cmd.op == DP_DIV_R) begin
            div_num = DIFF_W'(kd_reg) - DIFF_W'(t_reg);
            div_den = DIFF_W'(kd_reg) - DIFF_W'(kb_reg);
        end else begin
            div_num = DIFF_W'(t_reg) - DIFF_W'(ka_reg);
            div_den = DIFF_W'(kc_reg) - DIFF_W'(ka_reg);
        end
        mul_coef = (cmd.op == DP_MUL_R) ? r_reg : l_reg;
        prod     = mul_coef * work_q;
        acc_sh   = acc_reg[ACC_W-1:FRAC_W];
        wb_val   = (acc_sh > (ACC_W-FRAC_W)'(ONE_Q16)) ? ONE_Q16 : acc_sh[COEF_W-1:0];
        ind      = (ka_reg <= t_reg) && (t_reg < kb_reg);
    end

    bsbe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.op == DP_DIV_L || cmd.op == DP_DIV_R),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_r_reg <= 1'b0;
        end else if (cmd.op == DP_DIV_L || cmd.op == DP_DIV_R) begin
            sel_r_reg <= (cmd.op == DP_DIV_R);
        end
        if (div_done) begin
            if (sel_r_reg) begin
                r_reg <= div_quo;
            end else begin
                l_reg <= div_quo;
            end
        end
        case (cmd.op)
            DP_KNOT_WR: begin
                if (32'(in_word.knot_index) < MAX_KNOTS) begin
                    knot_mem[KIW'(in_word.knot_index)] <= in_word.knot_value;
                end
            end
            DP_LOAD_T: t_reg  <= in_word.eval_point;
            DP_LD_KA:  ka_reg <= knot_q;
            DP_LD_KB:  kb_reg <= knot_q;
            DP_LD_KC:  kc_reg <= knot_q;
            DP_LD_KD:  kd_reg <= knot_q;
            DP_IND:    work_mem[work_addr] <= ind ? ONE_Q16 : '0;
            DP_MUL_L:  acc_reg <= ACC_W'(prod);
            DP_MUL_R:  acc_reg <= acc_reg + ACC_W'(prod);
            DP_WB:     work_mem[work_addr] <= wb_val;
            DP_OUT:    out_reg <= work_q;
            default: ;
        endcase
    end

    assign status.div_done = div_done;
    assign out_value       = out_reg;

endmodule

// ----- rtl/bsbe_ctrl.sv -----
// Controller: configuration registers, recursion sequencer and output handshake.
module bsbe_ctrl #(
    parameter int unsigned MAX_KNOTS  = 16,
    parameter int unsigned MAX_DEGREE = 7,
    parameter int unsigned KIW = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [4:0]            cfg_wr_data,
    input  logic                  s_valid,
    input  logic                  s_operation,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_index,
    output logic                  m_last,
    output bsbe_pkg::dp_cmd_t     cmd,
    output logic [KIW-1:0]        knot_addr,
    output logic [KIW-1:0]        work_addr,
    input  bsbe_pkg::dp_status_t  status
);
    import bsbe_pkg::*;

    localparam int unsigned AW = KIW + 5;

    typedef enum logic [4:0] {
        ST_IDLE, ST_IND_A, ST_IND_B, ST_IND_W,
        ST_KA, ST_KB, ST_KC, ST_KD,
        ST_DIVL, ST_WAITL, ST_DIVR, ST_WAITR,
        ST_MULL, ST_MULR, ST_WB, ST_OUT_LD, ST_OUT_WAIT
    } state_t;

    state_t          state_reg;
    logic [2:0]      deg_reg;
    logic [4:0]      kc_reg;
    logic [AW-1:0]   i_reg;
    logic [2:0]      p_reg;
    logic            m_valid_reg, m_last_reg;
    logic [3:0]      m_index_reg;

    logic [AW-1:0]   n, d, p_ext, cnt;
    logic            accept;

    always_comb begin
        n      = (32'(kc_reg) > MAX_KNOTS) ? AW'(MAX_KNOTS) : AW'(kc_reg);
        d      = (32'(deg_reg) > MAX_DEGREE) ? AW'(MAX_DEGREE) : AW'(deg_reg);
        p_ext  = AW'(p_reg);
        cnt    = n - d - AW'(1);
        accept = s_valid && (state_reg == ST_IDLE);

        knot_addr = KIW'(i_reg);
        work_addr = KIW'(i_reg);
        cmd.op    = DP_NOP;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) begin
                cmd.op = (s_operation == OPER_KNOT_WRITE) ? DP_KNOT_WR : DP_LOAD_T;
            end
            ST_IND_A: cmd.op = DP_LD_KA;
            ST_IND_B: begin
                cmd.op = DP_LD_KB;
                knot_addr = KIW'(i_reg + AW'(1));
            end
            ST_IND_W: cmd.op = DP_IND;
            ST_KA:    cmd.op = DP_LD_KA;
            ST_KB: begin
                cmd.op = DP_LD_KB;
                knot_addr = KIW'(i_reg + AW'(1));
            end
            ST_KC: begin
                cmd.op = DP_LD_KC;
                knot_addr = KIW'(i_reg + p_ext);
            end
            ST_KD: begin
                cmd.op = DP_LD_KD;
                knot_addr = KIW'(i_reg + p_ext + AW'(1));
            end
            ST_DIVL:  cmd.op = DP_DIV_L;
            ST_DIVR:  cmd.op = DP_DIV_R;
            ST_MULL:  cmd.op = DP_MUL_L;
            ST_MULR: begin
                cmd.op = DP_MUL_R;
                work_addr = KIW'(i_reg + AW'(1));
            end
            ST_WB:    cmd.op = DP_WB;
            ST_OUT_LD: cmd.op = DP_OUT;
            ST_WAITL, ST_WAITR, ST_OUT_WAIT: cmd.op = DP_NOP;
            default:  cmd.op = DP_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            deg_reg     <= 3'd3;
            kc_reg      <= 5'd8;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
            m_index_reg <= '0;
            i_reg       <= '0;
            p_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_SPLINE_DEGREE: deg_reg <= cfg_wr_data[2:0];
                    CFG_KNOT_COUNT:    kc_reg  <= cfg_wr_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && s_operation == OPER_EVALUATE &&
                        n >= AW'(2) && d < n - AW'(1)) begin
                        i_reg     <= '0;
                        p_reg     <= '0;
                        state_reg <= ST_IND_A;
                    end
                end
                ST_IND_A: state_reg <= ST_IND_B;
                ST_IND_B: state_reg <= ST_IND_W;
                ST_IND_W: begin
                    if (i_reg + AW'(2) < n) begin
                        i_reg     <= i_reg + AW'(1);
                        state_reg <= ST_IND_A;
                    end else if (d == '0) begin
                        i_reg     <= '0;
                        state_reg <= ST_OUT_LD;
                    end else begin
                        i_reg     <= '0;
                        p_reg     <= 3'd1;
                        state_reg <= ST_KA;
                    end
                end
                ST_KA:   state_reg <= ST_KB;
                ST_KB:   state_reg <= ST_KC;
                ST_KC:   state_reg <= ST_KD;
                ST_KD:   state_reg <= ST_DIVL;
                ST_DIVL: state_reg <= ST_WAITL;
                ST_WAITL: if (status.div_done) begin
                    state_reg <= ST_DIVR;
                end
                ST_DIVR: state_reg <= ST_WAITR;
                ST_WAITR: if (status.div_done) begin
                    state_reg <= ST_MULL;
                end
                ST_MULL: state_reg <= ST_MULR;
                ST_MULR: state_reg <= ST_WB;
                ST_WB: begin
                    if (i_reg + p_ext + AW'(2) < n) begin
                        i_reg     <= i_reg + AW'(1);
                        state_reg <= ST_KA;
                    end else if (p_ext == d) begin
                        i_reg     <= '0;
                        state_reg <= ST_OUT_LD;
                    end else begin
                        i_reg     <= '0;
                        p_reg     <= p_reg + 3'd1;
                        state_reg <= ST_KA;
                    end
                end
                ST_OUT_LD: begin
                    m_valid_reg <= 1'b1;
                    m_index_reg <= 4'(i_reg);
                    m_last_reg  <= (i_reg + AW'(1) == cnt);
                    state_reg   <= ST_OUT_WAIT;
                end
                ST_OUT_WAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            i_reg     <= i_reg + AW'(1);
                            state_reg <= ST_OUT_LD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_index = m_index_reg;
    assign m_last  = m_last_reg;

endmodule
